// ----- sv/eecs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emulated EEPROM checksum store package
// Shared operation codes, state encoding, control structures and constants.
// ----------------------------------------------------------------------------
package eecs_pkg;

	// Default size of the cached flash page in bytes.
	localparam int unsigned PAGE_BYTES_DEF = 1024;

	// Value of an erased flash byte.
	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	typedef enum logic [2:0] {
		OP_READ      = 3'd0,
		OP_WRITE     = 3'd1,
		OP_BWR_BYTE  = 3'd2,
		OP_BWR_CLOSE = 3'd3,
		OP_BRD_BYTE  = 3'd4,
		OP_BRD_CLOSE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} dp_status_t;

endpackage

// ----- sv/emulated_eeprom_checksum_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emulated EEPROM checksum store
// Byte cache of one flash page with a rotate-and-add running checksum.
// ----------------------------------------------------------------------------
//
// A request is taken on a rising edge where start is high and busy is low.
// Every request yields exactly one result, shown on read_data, checksum_ok
// and flush_request for a single cycle while done is high. The receiver
// cannot hold results off, so it must capture them in that cycle. A request
// is registered, run in the execute state, and its result registered with
// done. A new request can be taken in the same cycle that the previous
// result is shown, but not while the previous request executes. The flow is
// set by the page cache memory: its registered read is taken as the request
// is captured, and the read-modify-write and checksum update follow in the
// execute state. After reset the block runs a clearing pass that writes the
// erased value 0xFF to every cache byte, one byte a cycle, so busy stays
// high until all PAGE_BYTES bytes (1024 by default) are written, before the
// first request is taken. Flash erasure and programming are not carried
// out here: when the cache must be written back, the result carries
// flush_request for the host.
//
module emulated_eeprom_checksum_store
	import eecs_pkg::*;
#(
	parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [15:0] byte_address,
	input  logic [7:0]  write_data,
	input  logic        first_of_block,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        checksum_ok,
	output logic        flush_request
);

	// Command and status buses between the controller and the datapath.
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// The controller owns the sequencing: clearing pass, capture, execute.
	eecs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the cache, the running checksum and the result
	// registers, and acts only on the controller's commands.
	eecs_dp #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.byte_address   (byte_address),
		.write_data     (write_data),
		.first_of_block (first_of_block),
		.done           (done),
		.read_data      (read_data),
		.checksum_ok    (checksum_ok),
		.flush_request  (flush_request)
	);

	// A request taken at the ports is followed by its result.
	a_request_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result missing two cycles after a request");

	// Two results are never shown in consecutive cycles.
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	// The block is busy in the cycle after a request is taken.
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("not busy after a request");

endmodule

// ----- sv/eecs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module eecs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/eecs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emulated EEPROM checksum store controller
// Sequences the clearing pass after reset and the capture-and-execute request flow.
// ----------------------------------------------------------------------------
module eecs_ctrl
	import eecs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A captured request is always executed in the following cycle.
	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.execute)
		else $error("capture not followed by execute");

	// Execution lasts one cycle and the block is free again afterwards.
	a_exec_then_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> !busy && !cmd.execute)
		else $error("execute not followed by idle");

	// No request is taken while the clearing pass runs.
	a_no_capture_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_step |-> !cmd.capture && busy)
		else $error("capture during clearing pass");

endmodule

// ----- sv/eecs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Emulated EEPROM checksum store datapath
// Page cache memory, running checksum, clearing counter and result registers.
// ----------------------------------------------------------------------------
module eecs_dp
	import eecs_pkg::*;
#(
	parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  status,
	input  logic [2:0]  operation,
	input  logic [15:0] byte_address,
	input  logic [7:0]  write_data,
	input  logic        first_of_block,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        checksum_ok,
	output logic        flush_request
);

	localparam int unsigned AW = $clog2(PAGE_BYTES);
	localparam logic [16:0] PAGE_LIMIT = 17'(PAGE_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_BYTES - 1);

	// Request registers.
	op_t          op_q;
	logic [AW-1:0] addr_q;
	logic         in_range_q;
	logic [7:0]   data_q;
	logic         first_q;

	logic [7:0]    csum_q;
	logic [7:0]    csum_d;
	logic [AW-1:0] clr_q;

	logic       done_q;
	logic [7:0] rd_q;
	logic       ok_q;
	logic       flush_q;

	logic [7:0] rd_val;
	logic [7:0] base;
	logic [7:0] rot;
	logic [7:0] rd_d;
	logic       ok_d;
	logic       flush_d;
	logic       ex_we;
	logic [7:0] ex_wdata;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	eecs_ram #(
		.WIDTH (8),
		.DEPTH (PAGE_BYTES)
	) u_cache (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.capture),
		.raddr (byte_address[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op_t'(operation);
			addr_q     <= byte_address[AW-1:0];
			in_range_q <= {1'b0, byte_address} < PAGE_LIMIT;
			data_q     <= write_data;
			first_q    <= first_of_block;
		end
	end

	always_comb begin
		rd_val = in_range_q ? ram_rdata : ERASED_BYTE;
		base   = csum_q;
		if (first_q && (op_q inside {OP_BWR_BYTE, OP_BWR_CLOSE, OP_BRD_BYTE,
				OP_BRD_CLOSE})) begin
			base = 8'd0;
		end
		rot      = {base[6:0], base[7]};
		csum_d   = csum_q;
		rd_d     = 8'd0;
		ok_d     = 1'b0;
		flush_d  = 1'b0;
		ex_we    = 1'b0;
		ex_wdata = data_q;
		case (op_q)
			OP_READ: begin
				rd_d = rd_val;
			end
			OP_WRITE: begin
				if (in_range_q && (ram_rdata != data_q)) begin
					ex_we   = 1'b1;
					flush_d = 1'b1;
				end
			end
			OP_BWR_BYTE: begin
				csum_d = rot + data_q;
				ex_we  = in_range_q;
			end
			OP_BWR_CLOSE: begin
				csum_d   = base;
				ex_we    = in_range_q;
				ex_wdata = base;
				flush_d  = 1'b1;
			end
			OP_BRD_BYTE: begin
				rd_d   = rd_val;
				csum_d = rot + rd_val;
			end
			OP_BRD_CLOSE: begin
				rd_d   = rd_val;
				ok_d   = rd_val == base;
				csum_d = base;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (cmd.clear_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = ERASED_BYTE;
		end else begin
			ram_we    = cmd.execute && ex_we;
			ram_waddr = addr_q;
			ram_wdata = ex_wdata;
		end
	end

	assign status.clear_last = clr_q == LAST_ADDR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			csum_q <= 8'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.execute) begin
				csum_q <= csum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rd_q    <= rd_d;
			ok_q    <= ok_d;
			flush_q <= flush_d;
		end
	end

	assign done          = done_q;
	assign read_data     = rd_q;
	assign checksum_ok   = ok_q;
	assign flush_request = flush_q;

	// A result strobe only ever follows an executed request.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cmd.execute))
		else $error("result without execution");

	// The cache is never written outside the clearing pass or an execution.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> cmd.clear_step || cmd.execute)
		else $error("stray cache write");

endmodule
